### rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg: shared constants and helpers for the permutation shuffler
// Store geometry, operation codes and the xorshift generator step.
// ----------------------------------------------------------------------------
package rps_pkg;

    // Store geometry
    localparam int PERM_SIZE = 4096;
    localparam int ADDR_W    = $clog2(PERM_SIZE);
    // Bound i+1 reaches PERM_SIZE itself
    localparam int BND_W     = $clog2(PERM_SIZE + 1);
    // Width for range checks of the index field against PERM_SIZE
    localparam int CMP_W     = (ADDR_W + 1 > 12) ? ADDR_W + 1 : 13;

    // Field widths
    localparam int OP_W  = 2;
    localparam int IDX_W = 12;
    localparam int VAL_W = 12;
    localparam int GEN_W = 64;
    localparam int CNT_W = $clog2(GEN_W);

    // Xorshift shift amounts
    localparam int SH_A = 13;
    localparam int SH_B = 7;
    localparam int SH_C = 17;

    // Operation codes
    localparam logic [OP_W-1:0] OP_RESEED  = 2'd0;
    localparam logic [OP_W-1:0] OP_SHUFFLE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    typedef logic [GEN_W-1:0] t_gen;

    // One xorshift step
    function automatic t_gen xs_step(input t_gen x);
        t_gen a;
        t_gen b;
        a = x ^ (x << SH_A);
        b = a ^ (a >> SH_B);
        return b ^ (b << SH_C);
    endfunction

endpackage

### rtl/random_permutation_shuffler_core.sv
// ----------------------------------------------------------------------------
// random_permutation_shuffler_core
// Xorshift64 generator plus a Fisher-Yates shuffled permutation store.
// ----------------------------------------------------------------------------
// Ops: reseed (generator takes the seed register), shuffle (identity fill,
// then one swap per index from the top down to 1 using next_random mod
// (i+1)), read (entry at index, zero if out of range or never shuffled).
// One result beat per input beat, each op handled alone. In a shuffle
// the fill writes one entry a cycle, and each swap takes one generator
// step, then the bit-serial remainder unit (one dividend bit a cycle),
// then the store accesses for the swap (read entry j, write entry i,
// write entry j). A finished result sits in the output register while
// the next input beat is taken.
// ----------------------------------------------------------------------------
module random_permutation_shuffler_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [rps_pkg::GEN_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [rps_pkg::OP_W-1:0]  i_op,
    input  logic [rps_pkg::IDX_W-1:0] i_index,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [rps_pkg::VAL_W-1:0] o_value,
    output logic                      o_done_res
);
    import rps_pkg::*;

    // State codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_GEN  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_RDJ  = 4'd4;
    localparam logic [3:0] S_WRI  = 4'd5;
    localparam logic [3:0] S_WRJ  = 4'd6;
    localparam logic [3:0] S_RDW  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [GEN_W-1:0]  r_seed;
    logic [GEN_W-1:0]  r_gen, n_gen;
    logic [GEN_W-1:0]  r_sh, n_sh;
    logic [BND_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [VAL_W-1:0]  r_tmp, n_tmp;
    logic              r_shuffled, n_shuffled;
    logic [VAL_W-1:0]  r_res_value, n_res_value;
    logic              r_res_done, n_res_done;
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_value, n_value;
    logic              r_done, n_done;

    // Store
    logic [VAL_W-1:0]  r_mem [PERM_SIZE];
    logic [VAL_W-1:0]  r_rdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [ADDR_W-1:0] w_waddr;
    logic [VAL_W-1:0]  w_wdata;
    logic              w_we;

    logic              w_in_acc;
    logic              w_slot_free;
    logic              w_in_range;
    logic [BND_W-1:0]  w_bound;
    logic [BND_W:0]    w_trial;
    logic [BND_W:0]    w_diff;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_in_range  = CMP_W'(i_index) < CMP_W'(PERM_SIZE);

    // Remainder step: shift in one dividend bit, subtract bound if it fits
    assign w_bound = BND_W'(r_i) + BND_W'(1);
    assign w_trial = {r_rem, r_sh[GEN_W-1]};
    assign w_diff  = w_trial - {1'b0, w_bound};

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_gen       = r_gen;
        n_sh        = r_sh;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_i         = r_i;
        n_tmp       = r_tmp;
        n_shuffled  = r_shuffled;
        n_res_value = r_res_value;
        n_res_done  = r_res_done;
        n_out_valid = r_out_valid;
        n_value     = r_value;
        n_done      = r_done;
        w_raddr     = r_i;
        w_waddr     = r_k;
        w_wdata     = VAL_W'(r_k);
        w_we        = 1'b0;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                w_raddr = ADDR_W'(i_index);
                if (w_in_acc) begin
                    n_res_value = '0;
                    n_res_done  = 1'b0;
                    case (i_op)
                        OP_RESEED: begin
                            n_gen      = r_seed;
                            n_res_done = 1'b1;
                            n_state    = S_FIN;
                        end
                        OP_SHUFFLE: begin
                            n_k     = '0;
                            n_state = S_FILL;
                        end
                        OP_READ: begin
                            n_state = (r_shuffled && w_in_range) ? S_RDW : S_FIN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            // Identity fill, one entry a cycle
            S_FILL: begin
                w_we = 1'b1;
                n_k  = r_k + ADDR_W'(1);
                if (r_k == ADDR_W'(PERM_SIZE - 1)) begin
                    n_i     = r_k;
                    n_state = S_GEN;
                end
            end
            // Next random value into the dividend shifter
            S_GEN: begin
                n_gen   = xs_step(r_gen);
                n_sh    = xs_step(r_gen);
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            // Bit-serial remainder; store read of entry i runs alongside
            S_DIV: begin
                n_sh  = r_sh << 1;
                n_rem = w_diff[BND_W] ? BND_W'(w_trial) : BND_W'(w_diff);
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(GEN_W - 1)) begin
                    n_state = S_RDJ;
                end
            end
            // Hold entry i, read entry j
            S_RDJ: begin
                n_tmp   = r_rdata;
                w_raddr = ADDR_W'(r_rem);
                n_state = S_WRI;
            end
            S_WRI: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_rdata;
                n_state = S_WRJ;
            end
            S_WRJ: begin
                w_we    = 1'b1;
                w_waddr = ADDR_W'(r_rem);
                w_wdata = r_tmp;
                if (r_i == ADDR_W'(1)) begin
                    n_shuffled = 1'b1;
                    n_res_done = 1'b1;
                    n_state    = S_FIN;
                end else begin
                    n_i     = r_i - ADDR_W'(1);
                    n_state = S_GEN;
                end
            end
            // Read data is back
            S_RDW: begin
                n_res_value = r_rdata;
                n_state     = S_FIN;
            end
            // Hand the result to the output register
            S_FIN: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_value     = r_res_value;
                    n_done      = r_res_done;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= GEN_W'(1);
            r_gen       <= GEN_W'(1);
            r_shuffled  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_shuffled  <= n_shuffled;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_sh        <= n_sh;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_k         <= n_k;
        r_i         <= n_i;
        r_tmp       <= n_tmp;
        r_res_value <= n_res_value;
        r_res_done  <= n_res_done;
        r_value     <= n_value;
        r_done      <= n_done;
    end

    // Permutation store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_done_res  = r_done;

    // Checks
    a_shuf_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_op == OP_SHUFFLE) |=> (r_state == S_FILL))
        else $error("shuffle did not start with the fill");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_RDJ) |-> (r_rem < w_bound))
        else $error("remainder escaped its bound");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (o_value == '0))
        else $error("completion beat carries a nonzero value");

endmodule
